### rtl/brte_pkg.sv
package brte_pkg;
	localparam int MaxRoutes = 64;
	localparam int TableDepth = MaxRoutes + 1;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int MacW = 48;
	localparam int NodeW = 40;
	localparam int OutCntW = 7;

	localparam logic REQ_LEARN = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [MacW-1:0]  mac_addr;
		logic [NodeW-1:0] node_addr;
	} brte_req_t;

	typedef struct packed {
		logic                hit;
		logic [NodeW-1:0]    found_node;
		logic                evicted;
		logic [NodeW-1:0]    evicted_node;
		logic [OutCntW-1:0]  evicted_count;
		logic [OutCntW-1:0]  occupancy;
	} brte_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND,
		ST_FIND_CHK,
		ST_APPLY,
		ST_OUTER,
		ST_NODE,
		ST_COUNT,
		ST_SCORE,
		ST_PURGE,
		ST_PURGE_CHK,
		ST_DONE
	} brte_state_t;
endpackage

### rtl/brte_if.sv
interface brte_req_if import brte_pkg::*; ();
	logic      valid;
	logic      ready;
	brte_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface brte_rsp_if import brte_pkg::*; ();
	logic      valid;
	logic      ready;
	brte_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/bridge_route_table_with_eviction.sv
// A request is taken in ST_IDLE; ST_FIND and ST_FIND_CHK then read the entries from
// index 0 until the MAC matches or the last entry is read, and a learn writes in ST_APPLY.
// An overflowing learn then counts, for each valid entry, the entries of its node, picks
// the victim node in ST_SCORE and purges its entries before the result is registered.
// One transaction in flight; the next is taken the cycle after the result is registered.
// Reset clears valid bits, the entry count and control; entry memory is not cleared.
module bridge_route_table_with_eviction import brte_pkg::*; (
	input logic clk,
	input logic arst_n,
	brte_req_if.sink req,
	brte_rsp_if.source rsp
);
	logic [MacW+NodeW-1:0] mem [TableDepth];
	logic [MacW+NodeW-1:0] rd_s1;
	logic [IdxW-1:0]       scan_s1;
	logic [TableDepth-1:0] valid_q;
	logic [CntW-1:0]       total_q;

	brte_state_t state_q, state_d;
	brte_req_t        req_q;
	logic [IdxW-1:0]  ptr_q, outer_q, slot_q;
	logic             slot_hit_q;
	logic [NodeW-1:0] cur_node_q, best_node_q;
	logic [CntW-1:0]  cnt_q, best_cnt_q, removed_q;
	logic [MacW-1:0]  last_q, best_last_q;
	logic             best_ok_q;
	logic             rsp_valid_q;
	brte_rsp_t        rsp_q, rsp_d;

	logic [MacW-1:0]  rd_mac;
	logic [NodeW-1:0] rd_node;
	logic             ptr_last, scan_last, outer_last;
	logic [IdxW-1:0]  ptr_inc;
	logic             mac_match, count_match, purge_match;
	logic             better, insert, overflow, rsp_free;
	logic [IdxW-1:0]  free_idx;
	logic             free_ok;
	logic [CntW-1:0]  total_new;
	logic             wr_en;
	logic [IdxW-1:0]  wr_idx;

	assign rd_mac = rd_s1[MacW+NodeW-1:NodeW];
	assign rd_node = rd_s1[NodeW-1:0];
	assign ptr_last = (ptr_q == IdxW'(TableDepth - 1));
	assign scan_last = (scan_s1 == IdxW'(TableDepth - 1));
	assign outer_last = (outer_q == IdxW'(TableDepth - 1));
	assign ptr_inc = ptr_last ? ptr_q : ptr_q + 1'b1;

	// rd_s1 always holds the entry addressed by scan_s1
	assign mac_match = valid_q[scan_s1] && (rd_mac == req_q.mac_addr);
	assign count_match = valid_q[scan_s1] && (rd_node == cur_node_q);
	assign purge_match = valid_q[scan_s1] && (rd_node == best_node_q);
	assign better = valid_q[outer_q] && (!best_ok_q || cnt_q > best_cnt_q ||
		(cnt_q == best_cnt_q && last_q < best_last_q));
	assign insert = (req_q.req_type == REQ_LEARN) && !slot_hit_q && free_ok;
	assign overflow = insert && (total_q >= CntW'(MaxRoutes));
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign total_new = best_ok_q ? total_q - removed_q : total_q;
	assign wr_en = (state_q == ST_APPLY) && (req_q.req_type == REQ_LEARN) &&
		(slot_hit_q || free_ok);
	assign wr_idx = slot_hit_q ? slot_q : free_idx;

	always_comb begin
		free_idx = '0;
		free_ok = 1'b0;
		for (int i = TableDepth - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IdxW'(i);
				free_ok = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_s1 <= mem[ptr_q];
		scan_s1 <= ptr_q;
		if (wr_en)
			mem[wr_idx] <= {req_q.mac_addr, req_q.node_addr};
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (req.valid) state_d = ST_FIND;
			ST_FIND:      state_d = ST_FIND_CHK;
			ST_FIND_CHK:  if (mac_match || scan_last) state_d = ST_APPLY;
			ST_APPLY:     state_d = overflow ? ST_OUTER : ST_DONE;
			ST_OUTER:     state_d = valid_q[outer_q] ? ST_NODE : ST_SCORE;
			ST_NODE:      state_d = ST_COUNT;
			ST_COUNT:     if (scan_last) state_d = ST_SCORE;
			ST_SCORE:     state_d = outer_last ? ST_PURGE : ST_OUTER;
			ST_PURGE:     state_d = ST_PURGE_CHK;
			ST_PURGE_CHK: if (scan_last) state_d = ST_DONE;
			ST_DONE:      if (rsp_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rsp_d = '0;
		rsp_d.hit = slot_hit_q;
		if (req_q.req_type == REQ_LOOKUP && slot_hit_q)
			rsp_d.found_node = cur_node_q;
		if (best_ok_q) begin
			rsp_d.evicted = 1'b1;
			rsp_d.evicted_node = best_node_q;
			rsp_d.evicted_count = OutCntW'(removed_q);
		end
		rsp_d.occupancy = OutCntW'(total_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
			rsp_valid_q <= 1'b0;
			ptr_q <= '0;
			outer_q <= '0;
			best_ok_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && rsp_free)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid)
						ptr_q <= '0;
				end
				ST_FIND, ST_FIND_CHK, ST_NODE, ST_COUNT, ST_PURGE:
					ptr_q <= ptr_inc;
				ST_APPLY: begin
					if (insert) begin
						valid_q[free_idx] <= 1'b1;
						total_q <= total_q + 1'b1;
					end
					ptr_q <= '0;
					outer_q <= '0;
					best_ok_q <= 1'b0;
				end
				ST_OUTER:
					ptr_q <= '0;
				ST_SCORE: begin
					if (better)
						best_ok_q <= 1'b1;
					// the next outer entry is read while the state returns to ST_OUTER
					if (outer_last)
						ptr_q <= '0;
					else begin
						outer_q <= outer_q + 1'b1;
						ptr_q <= outer_q + 1'b1;
					end
				end
				ST_PURGE_CHK: begin
					ptr_q <= ptr_inc;
					if (purge_match)
						valid_q[scan_s1] <= 1'b0;
				end
				ST_DONE: begin
					if (rsp_free)
						total_q <= total_new;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					req_q <= req.data;
					slot_hit_q <= 1'b0;
				end
			end
			ST_FIND_CHK: begin
				if (mac_match) begin
					slot_hit_q <= 1'b1;
					slot_q <= scan_s1;
					cur_node_q <= rd_node;
				end
			end
			ST_NODE: begin
				cur_node_q <= rd_node;
				cnt_q <= '0;
				last_q <= '0;
			end
			ST_COUNT: begin
				if (count_match) begin
					cnt_q <= cnt_q + 1'b1;
					if (rd_mac > last_q)
						last_q <= rd_mac;
				end
			end
			ST_SCORE: begin
				if (better) begin
					best_cnt_q <= cnt_q;
					best_last_q <= last_q;
					best_node_q <= cur_node_q;
				end
				removed_q <= '0;
			end
			ST_PURGE_CHK: begin
				if (purge_match)
					removed_q <= removed_q + 1'b1;
			end
			ST_DONE: begin
				if (rsp_free)
					rsp_q <= rsp_d;
			end
			default: ;
		endcase
	end
endmodule

### test/bridge_route_table_with_eviction_tb.sv
module bridge_route_table_with_eviction_tb;
	import brte_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	brte_req_if req ();
	brte_rsp_if rsp ();

	bridge_route_table_with_eviction i_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow route table
	logic [MacW-1:0]  tbl_mac [TableDepth];
	logic [NodeW-1:0] tbl_node [TableDepth];
	logic             tbl_valid [TableDepth];
	int               tbl_total;

	brte_rsp_t rsp_pending [$];
	int errors = 0;
	int cycles = 0;
	int n_learn = 0, n_lookup = 0, n_evict = 0, n_hit = 0;
	bit stall_hold = 0;
	bit calm = 0;
	bit stim_done = 0;

	localparam int CycleLimit = 6000000;

	function automatic int find_slot(logic [MacW-1:0] mac);
		for (int i = 0; i < TableDepth; i++)
			if (tbl_valid[i] && tbl_mac[i] == mac)
				return i;
		return -1;
	endfunction

	function automatic brte_rsp_t route_predict(brte_req_t r);
		brte_rsp_t o;
		int slot;
		int best, best_cnt, cnt, removed;
		logic [MacW-1:0] best_last, last;
		logic [NodeW-1:0] victim;
		o = '0;
		slot = find_slot(r.mac_addr);
		if (r.req_type == REQ_LOOKUP) begin
			if (slot >= 0) begin
				o.hit = 1'b1;
				o.found_node = tbl_node[slot];
			end
		end else begin
			if (slot >= 0) begin
				o.hit = 1'b1;
				tbl_node[slot] = r.node_addr;
			end else begin
				for (int i = 0; i < TableDepth; i++)
					if (!tbl_valid[i]) begin
						tbl_valid[i] = 1'b1;
						tbl_mac[i] = r.mac_addr;
						tbl_node[i] = r.node_addr;
						tbl_total++;
						break;
					end
			end
			if (tbl_total > MaxRoutes) begin
				best = -1;
				best_cnt = 0;
				best_last = '0;
				for (int i = 0; i < TableDepth; i++) begin
					if (!tbl_valid[i])
						continue;
					cnt = 0;
					last = '0;
					for (int j = 0; j < TableDepth; j++)
						if (tbl_valid[j] && tbl_node[j] == tbl_node[i]) begin
							cnt++;
							if (tbl_mac[j] > last)
								last = tbl_mac[j];
						end
					if (best < 0 || cnt > best_cnt || (cnt == best_cnt && last < best_last)) begin
						best = i;
						best_cnt = cnt;
						best_last = last;
					end
				end
				victim = tbl_node[best];
				removed = 0;
				for (int i = 0; i < TableDepth; i++)
					if (tbl_valid[i] && tbl_node[i] == victim) begin
						tbl_valid[i] = 1'b0;
						removed++;
					end
				tbl_total -= removed;
				o.evicted = 1'b1;
				o.evicted_node = victim;
				o.evicted_count = OutCntW'(removed);
			end
		end
		o.occupancy = OutCntW'(tbl_total);
		return o;
	endfunction

	// directed table; fixed expectations where they are obvious
	typedef struct {
		brte_req_t rq;
		bit        chk;
		brte_rsp_t exp;
	} route_row_t;

	route_row_t directed [$];

	function automatic brte_req_t mk(logic t, logic [MacW-1:0] m, logic [NodeW-1:0] n);
		brte_req_t r;
		r.req_type = t;
		r.mac_addr = m;
		r.node_addr = n;
		return r;
	endfunction

	function automatic brte_rsp_t rs(int h, logic [NodeW-1:0] fn, int occ);
		brte_rsp_t o;
		o = '0;
		o.hit = (h != 0);
		o.found_node = fn;
		o.occupancy = OutCntW'(occ);
		return o;
	endfunction

	task automatic send(brte_req_t r);
		req.valid <= 1'b1;
		req.data <= r;
		do @(posedge clk); while (!req.ready);
		if (r.req_type == REQ_LOOKUP)
			n_lookup++;
		else
			n_learn++;
		if (!calm && $urandom_range(99) < 8) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic push_item(brte_req_t r);
		brte_rsp_t p;
		p = route_predict(r);
		rsp_pending.push_back(p);
		send(r);
	endtask

	// Fills the table to capacity with a node mix, then overflows it.
	task automatic fill_and_overflow(int nodes, logic [MacW-1:0] base);
		logic [NodeW-1:0] pool [4];
		for (int k = 0; k < 4; k++)
			pool[k] = NodeW'({$urandom, $urandom});
		while (tbl_total < MaxRoutes)
			push_item(mk(REQ_LEARN, base + MacW'($urandom_range(0, 4000)),
				pool[$urandom_range(0, nodes - 1)]));
		push_item(mk(REQ_LEARN, base + MacW'(5000), pool[$urandom_range(0, nodes - 1)]));
	endtask

	task automatic random_item();
		brte_req_t r;
		logic [MacW-1:0] m;
		int s;
		m = MacW'({$urandom, $urandom});
		if ($urandom_range(99) < 60) begin
			s = $urandom_range(0, TableDepth - 1);
			if (tbl_valid[s])
				m = tbl_mac[s];
		end
		r = mk(logic'($urandom_range(0, 1)), m, NodeW'({$urandom, $urandom}));
		push_item(r);
	endtask

	initial begin
		brte_rsp_t p;
		logic [MacW-1:0] mx;
		logic [NodeW-1:0] nx;
		mx = '1;
		nx = '1;
		for (int i = 0; i < TableDepth; i++)
			tbl_valid[i] = 1'b0;
		tbl_total = 0;
		req.valid <= 1'b0;
		req.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back('{mk(REQ_LOOKUP, '0, '0), 1, rs(0, '0, 0)});
		directed.push_back('{mk(REQ_LOOKUP, mx, nx), 1, rs(0, '0, 0)});
		directed.push_back('{mk(REQ_LEARN, '0, nx), 1, rs(0, '0, 1)});
		directed.push_back('{mk(REQ_LEARN, mx, '0), 1, rs(0, '0, 2)});
		directed.push_back('{mk(REQ_LOOKUP, '0, '0), 1, rs(1, nx, 2)});
		directed.push_back('{mk(REQ_LOOKUP, mx, nx), 1, rs(1, '0, 2)});
		directed.push_back('{mk(REQ_LEARN, mx, 40'h5555555555), 1, rs(1, '0, 2)});
		directed.push_back('{mk(REQ_LOOKUP, mx, '0), 1, rs(1, 40'h5555555555, 2)});
		directed.push_back('{mk(REQ_LEARN, 48'hAAAAAAAAAAAA, 40'hAAAAAAAAAA), 0, '0});
		directed.push_back('{mk(REQ_LEARN, 48'h555555555555, 40'hAAAAAAAAAA), 0, '0});
		directed.push_back('{mk(REQ_LOOKUP, 48'hAAAAAAAAAAAA, '0), 0, '0});
		directed.push_back('{mk(REQ_LOOKUP, 48'h123456789ABC, '0), 0, '0});
		foreach (directed[k]) begin
			p = route_predict(directed[k].rq);
			rsp_pending.push_back(directed[k].chk ? directed[k].exp : p);
			send(directed[k].rq);
		end

		// equal counts: tie goes to the node whose largest MAC is smaller
		calm = 1;
		while (tbl_total < MaxRoutes)
			push_item(mk(REQ_LEARN, 48'h0000_2000_0000 + MacW'(tbl_total),
				(tbl_total % 2) ? 40'h11 : 40'h22));
		push_item(mk(REQ_LEARN, 48'h0000_1FFF_0000, 40'h33));
		calm = 0;

		for (int k = 0; k < 30; k++)
			random_item();
		fill_and_overflow(3, 48'hFFFF_0000_0000);
		for (int k = 0; k < 15; k++)
			random_item();

		// long receiver hold-off with offers still coming
		stall_hold = 1;
		for (int k = 0; k < 6; k++)
			random_item();
		req.valid <= 1'b0;
		stim_done = 1;
	end

	initial begin
		int hold;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_hold) begin
				rsp.ready <= 1'b0;
				hold = 0;
				while (hold < 2000) begin
					@(posedge clk);
					hold++;
				end
				stall_hold = 0;
			end
			rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
		end
	end

	always @(posedge clk) begin
		brte_rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (rsp_pending.size() == 0) begin
				$display("%t: unexpected result %p", $realtime, rsp.data);
				errors++;
			end else begin
				e = rsp_pending.pop_front();
				if (e.evicted)
					n_evict++;
				if (e.hit)
					n_hit++;
				if (rsp.data.hit !== e.hit) begin
					$display("%t: hit exp %0h got %0h", $realtime, e.hit, rsp.data.hit);
					errors++;
				end
				if (rsp.data.found_node !== e.found_node) begin
					$display("%t: found_node exp %0h got %0h", $realtime,
						e.found_node, rsp.data.found_node);
					errors++;
				end
				if (rsp.data.evicted !== e.evicted) begin
					$display("%t: evicted exp %0h got %0h", $realtime,
						e.evicted, rsp.data.evicted);
					errors++;
				end
				if (rsp.data.evicted_node !== e.evicted_node) begin
					$display("%t: evicted_node exp %0h got %0h", $realtime,
						e.evicted_node, rsp.data.evicted_node);
					errors++;
				end
				if (rsp.data.evicted_count !== e.evicted_count) begin
					$display("%t: evicted_count exp %0d got %0d", $realtime,
						e.evicted_count, rsp.data.evicted_count);
					errors++;
				end
				if (rsp.data.occupancy !== e.occupancy) begin
					$display("%t: occupancy exp %0d got %0d", $realtime,
						e.occupancy, rsp.data.occupancy);
					errors++;
				end
			end
		end
	end

	initial begin
		while (!(stim_done && rsp_pending.size() == 0))
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("Covered %0d learns and %0d lookups; %0d hits, %0d evictions.",
			n_learn, n_lookup, n_hit, n_evict);
		if (errors == 0 && rsp_pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end
endmodule

### sim.f
rtl/brte_pkg.sv
rtl/brte_if.sv
rtl/bridge_route_table_with_eviction.sv
test/bridge_route_table_with_eviction_tb.sv
